>>> rtl/core/jhdp_pkg.sv
// Package for the JPEG header dimension parser.
// Holds the parse phase type, marker and status codes and the beat structs.
// Used by every module under rtl/core but jhdp_checker; depends on nothing.
package jhdp_pkg;

  // Parse phases, one per position in the marker grammar.
  typedef enum logic [2:0] {
    PH_START0 = 3'd0,  // expect the FF of the start marker
    PH_START1 = 3'd1,  // expect D8
    PH_HUNT   = 3'd2,  // hunt for an FF byte
    PH_MARKER = 3'd3,  // read the marker code, skipping fill FFs
    PH_LENHI  = 3'd4,  // segment length, high byte
    PH_LENLO  = 3'd5,  // segment length, low byte
    PH_BODY   = 3'd6,  // segment body
    PH_DONE   = 3'd7   // result given, wait for the end of the file
  } phase_t;

  // Marker bytes.
  localparam logic [7:0] BYTE_FILL   = 8'hFF;
  localparam logic [7:0] MRK_SOI     = 8'hD8;
  localparam logic [7:0] MRK_SOS     = 8'hDA;
  localparam logic [7:0] MRK_SOF0    = 8'hC0;
  localparam logic [7:0] MRK_APP0    = 8'hE0;
  localparam logic [7:0] MRK_TEM     = 8'h00;
  localparam logic [7:0] MRK_RES01   = 8'h01;
  localparam logic [7:0] MRK_RST_LO  = 8'hD0;
  localparam logic [7:0] MRK_RST_HI  = 8'hD7;

  // Result status codes.
  localparam logic [1:0] ST_SCAN      = 2'd0;
  localparam logic [1:0] ST_EOF       = 2'd1;
  localparam logic [1:0] ST_BAD_START = 2'd2;

  // Segment offsets of the captured bytes.
  localparam logic [15:0] OFF_SOF_HEIGHT_HI = 16'd3;
  localparam logic [15:0] OFF_SOF_HEIGHT_LO = 16'd4;
  localparam logic [15:0] OFF_SOF_WIDTH_HI  = 16'd5;
  localparam logic [15:0] OFF_SOF_WIDTH_LO  = 16'd6;
  localparam logic [15:0] OFF_APP_UNITS     = 16'd9;
  localparam logic [15:0] OFF_APP_DENX_HI   = 16'd10;
  localparam logic [15:0] OFF_APP_DENX_LO   = 16'd11;
  localparam logic [15:0] OFF_APP_DENY_HI   = 16'd12;
  localparam logic [15:0] OFF_APP_DENY_LO   = 16'd13;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;
  localparam logic [3:0]  HDR_CNT_MAX = 4'd15;

  // Width of the packed result bus, padded to whole bytes.
  localparam int OUT_TDATA_W = 80;

  // One input byte as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] density_x;
    logic [15:0] density_y;
    logic [7:0]  density_units;
    logic [3:0]  headers_found;
  } result_t;

endpackage

>>> rtl/core/jpeg_header_dimension_parser_top.sv
// Top level of the JPEG header dimension parser.
// Wires the input register, the marker parser and the result register.
// Depends on jhdp_pkg, jhdp_in_stage, jhdp_parser and jhdp_out_stage.
//
//  Channel  Direction  Beat content
//  in_*     sink       one file byte, tlast on the final byte of the file
//  out_*    source     one result: status, sizes, densities, header count
//
// Each byte is parsed straight out of the input register, and its result is
// written into the result register at the edge that consumes the byte; one
// byte is taken per cycle unless a byte that gives a result finds the result
// register full. Throughput is set by the single parse-state register
// update per byte. Reset is synchronous and active low and clears the parse
// state at once. While a result waits on out_tready, bytes that give no
// result keep flowing; a byte that gives a result waits.
module jpeg_header_dimension_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [jhdp_pkg::OUT_TDATA_W-1:0] out_tdata
                                  // [1:0] status, [17:2] image_width,
                                  // [33:18] image_height, [49:34] density_x,
                                  // [65:50] density_y, [73:66] density_units,
                                  // [77:74] headers_found, [79:78] zero
);

  jhdp_pkg::beat_t   in_beat;
  jhdp_pkg::beat_t   s1_beat;
  jhdp_pkg::result_t res;
  jhdp_pkg::result_t out_res;
  logic              s1_valid;
  logic              consume;
  logic              res_valid;
  logic              out_free;

  assign in_beat.data_byte = in_tdata;
  assign in_beat.last_byte = in_tlast;

  jhdp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_beat  (in_beat),
    .consume  (consume),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  jhdp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_beat   (s1_beat),
    .out_free  (out_free),
    .consume   (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  jhdp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid && consume),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result, first field in the lowest bits.
  assign out_tdata = {2'b00,
                      out_res.headers_found,
                      out_res.density_units,
                      out_res.density_y,
                      out_res.density_x,
                      out_res.image_height,
                      out_res.image_width,
                      out_res.status};

endmodule

>>> rtl/core/jhdp_in_stage.sv
// Input register of the JPEG header dimension parser.
// Holds one byte beat until the parser consumes it; uses jhdp_pkg.
// Feeds jhdp_parser.
module jhdp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  jhdp_pkg::beat_t in_beat,
  input  logic            consume,
  output logic            s1_valid,
  output jhdp_pkg::beat_t s1_beat
);

  logic            valid_r;
  logic            valid_nxt;
  jhdp_pkg::beat_t beat_r;

  // The register is free when empty or when its beat leaves this cycle.
  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule

>>> rtl/core/jhdp_parser.sv
// Marker parser of the JPEG header dimension parser.
// Holds the parse state and captured fields and forms the result of a byte.
// Uses jhdp_pkg; sits between jhdp_in_stage and jhdp_out_stage.
module jhdp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  jhdp_pkg::beat_t   s1_beat,
  input  logic              out_free,
  output logic              consume,
  output logic              res_valid,
  output jhdp_pkg::result_t res
);

  jhdp_pkg::phase_t phase_r, phase_step, phase_nxt;
  logic [7:0]  marker_r,  marker_step;
  logic [15:0] offset_r,  offset_step;
  logic [15:0] length_r,  length_step;
  logic [15:0] width_r,   width_step;
  logic [15:0] height_r,  height_step;
  logic [15:0] denx_r,    denx_step;
  logic [15:0] deny_r,    deny_step;
  logic [7:0]  units_r,   units_step;
  logic [3:0]  count_r,   count_step;

  logic [7:0]  b;
  logic        last;
  logic        is_standalone;
  logic [15:0] len_lo;
  logic [15:0] len_fixed;
  logic [15:0] off_inc;
  logic [16:0] off_end;
  logic        emit_now;
  logic [1:0]  emit_status;
  logic        emit_eof;

  assign b    = s1_beat.data_byte;
  assign last = s1_beat.last_byte;

  assign is_standalone = (b == jhdp_pkg::MRK_TEM) || (b == jhdp_pkg::MRK_RES01) ||
                         ((b >= jhdp_pkg::MRK_RST_LO) && (b <= jhdp_pkg::MRK_RST_HI));

  // Length with its low byte merged, raised to the minimum of two.
  assign len_lo    = {length_r[15:8], b};
  assign len_fixed = (len_lo < jhdp_pkg::MIN_SEG_LEN) ? jhdp_pkg::MIN_SEG_LEN : len_lo;

  // Body offset of this byte and the end-of-segment test.
  assign off_inc = offset_r + 16'd1;
  assign off_end = {1'b0, off_inc} + 17'd1;

  // Next phase of the marker grammar, before the end-of-file restart.
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      jhdp_pkg::PH_START0: begin
        phase_step = (b == jhdp_pkg::BYTE_FILL) ? jhdp_pkg::PH_START1 : jhdp_pkg::PH_DONE;
      end
      jhdp_pkg::PH_START1: begin
        phase_step = (b == jhdp_pkg::MRK_SOI) ? jhdp_pkg::PH_HUNT : jhdp_pkg::PH_DONE;
      end
      jhdp_pkg::PH_HUNT: begin
        if (b == jhdp_pkg::BYTE_FILL) phase_step = jhdp_pkg::PH_MARKER;
      end
      jhdp_pkg::PH_MARKER: begin
        priority if (b == jhdp_pkg::BYTE_FILL) begin
          phase_step = jhdp_pkg::PH_MARKER;
        end else if (b == jhdp_pkg::MRK_SOS) begin
          phase_step = jhdp_pkg::PH_DONE;
        end else if (is_standalone) begin
          phase_step = jhdp_pkg::PH_HUNT;
        end else begin
          phase_step = jhdp_pkg::PH_LENHI;
        end
      end
      jhdp_pkg::PH_LENHI: phase_step = jhdp_pkg::PH_LENLO;
      jhdp_pkg::PH_LENLO: begin
        phase_step = (len_fixed > jhdp_pkg::MIN_SEG_LEN) ? jhdp_pkg::PH_BODY
                                                         : jhdp_pkg::PH_HUNT;
      end
      jhdp_pkg::PH_BODY: begin
        if (off_end >= {1'b0, length_r}) phase_step = jhdp_pkg::PH_HUNT;
      end
      jhdp_pkg::PH_DONE: phase_step = jhdp_pkg::PH_DONE;
      default: phase_step = jhdp_pkg::PH_START0;
    endcase
  end

  // The last byte of a file always restarts the parser.
  assign phase_nxt = last ? jhdp_pkg::PH_START0 : phase_step;

  // Datapath updates and the result of this byte.
  always_comb begin
    marker_step = marker_r;
    offset_step = offset_r;
    length_step = length_r;
    width_step  = width_r;
    height_step = height_r;
    denx_step   = denx_r;
    deny_step   = deny_r;
    units_step  = units_r;
    count_step  = count_r;
    emit_now    = 1'b0;
    emit_status = jhdp_pkg::ST_SCAN;
    unique case (phase_r)
      jhdp_pkg::PH_START0: begin
        if (b != jhdp_pkg::BYTE_FILL) begin
          emit_now    = 1'b1;
          emit_status = jhdp_pkg::ST_BAD_START;
        end
      end
      jhdp_pkg::PH_START1: begin
        if (b != jhdp_pkg::MRK_SOI) begin
          emit_now    = 1'b1;
          emit_status = jhdp_pkg::ST_BAD_START;
        end
      end
      jhdp_pkg::PH_MARKER: begin
        if (b == jhdp_pkg::MRK_SOS) begin
          emit_now    = 1'b1;
          emit_status = jhdp_pkg::ST_SCAN;
        end else if (b != jhdp_pkg::BYTE_FILL && !is_standalone) begin
          marker_step = b;
          if ((b == jhdp_pkg::MRK_SOF0 || b == jhdp_pkg::MRK_APP0) &&
              count_r < jhdp_pkg::HDR_CNT_MAX) begin
            count_step = count_r + 4'd1;
          end
        end
      end
      jhdp_pkg::PH_LENHI: begin
        length_step = {b, 8'h00};
        offset_step = 16'd0;
      end
      jhdp_pkg::PH_LENLO: begin
        length_step = len_fixed;
        offset_step = 16'd1;
      end
      jhdp_pkg::PH_BODY: begin
        offset_step = off_inc;
        // Capture the header bytes into their halves.
        if (marker_r == jhdp_pkg::MRK_SOF0) begin
          if (off_inc == jhdp_pkg::OFF_SOF_HEIGHT_HI) height_step[15:8] = b;
          if (off_inc == jhdp_pkg::OFF_SOF_HEIGHT_LO) height_step[7:0]  = b;
          if (off_inc == jhdp_pkg::OFF_SOF_WIDTH_HI)  width_step[15:8]  = b;
          if (off_inc == jhdp_pkg::OFF_SOF_WIDTH_LO)  width_step[7:0]   = b;
        end else if (marker_r == jhdp_pkg::MRK_APP0) begin
          if (off_inc == jhdp_pkg::OFF_APP_UNITS)   units_step       = b;
          if (off_inc == jhdp_pkg::OFF_APP_DENX_HI) denx_step[15:8]  = b;
          if (off_inc == jhdp_pkg::OFF_APP_DENX_LO) denx_step[7:0]   = b;
          if (off_inc == jhdp_pkg::OFF_APP_DENY_HI) deny_step[15:8]  = b;
          if (off_inc == jhdp_pkg::OFF_APP_DENY_LO) deny_step[7:0]   = b;
        end
      end
      default: begin
      end
    endcase
  end

  // At the end of a file with no result yet, report how far parsing got.
  assign emit_eof = last && !emit_now && (phase_step != jhdp_pkg::PH_DONE);

  always_comb begin
    res_valid             = s1_valid && (emit_now || emit_eof);
    res.status            = emit_now ? emit_status :
                            ((phase_step == jhdp_pkg::PH_START0 ||
                              phase_step == jhdp_pkg::PH_START1) ?
                             jhdp_pkg::ST_BAD_START : jhdp_pkg::ST_EOF);
    res.image_width       = width_step;
    res.image_height      = height_step;
    res.density_x         = denx_step;
    res.density_y         = deny_step;
    res.density_units     = units_step;
    res.headers_found     = count_step;
  end

  // A byte leaves unless its result finds the output register full.
  assign consume = s1_valid && (!res_valid || out_free);

  // State update; the end of a file clears everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jhdp_pkg::PH_START0;
      marker_r <= 8'h00;
      offset_r <= 16'h0000;
      length_r <= 16'h0000;
      width_r  <= 16'h0000;
      height_r <= 16'h0000;
      denx_r   <= 16'h0000;
      deny_r   <= 16'h0000;
      units_r  <= 8'h00;
      count_r  <= 4'h0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      if (last) begin
        marker_r <= 8'h00;
        offset_r <= 16'h0000;
        length_r <= 16'h0000;
        width_r  <= 16'h0000;
        height_r <= 16'h0000;
        denx_r   <= 16'h0000;
        deny_r   <= 16'h0000;
        units_r  <= 8'h00;
        count_r  <= 4'h0;
      end else begin
        marker_r <= marker_step;
        offset_r <= offset_step;
        length_r <= length_step;
        width_r  <= width_step;
        height_r <= height_step;
        denx_r   <= denx_step;
        deny_r   <= deny_step;
        units_r  <= units_step;
        count_r  <= count_step;
      end
    end
  end

endmodule

>>> rtl/core/jhdp_out_stage.sv
// Result register of the JPEG header dimension parser.
// Holds one result beat until the sink takes it; uses jhdp_pkg.
// Fed by jhdp_parser.
module jhdp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jhdp_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output jhdp_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  jhdp_pkg::result_t res_r;

  // Free when empty or when the held beat is taken this cycle.
  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/core/jhdp_checker.sv
// Port checker for the JPEG header dimension parser.
// Watches the top level's ports only; bound to jpeg_header_dimension_parser_top.
// Depends on nothing but the top level's port list.
module jhdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("result status out of range");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[79:78] == 2'b00))
    else $error("result padding not zero");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An empty pipeline always takes a byte: after reset the input is ready.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind jpeg_header_dimension_parser_top jhdp_checker u_jhdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
